[rtl/vec3_length_and_normalize_assert.svh]
// assertion macros for the vec3 length and normalize block
// no dependencies; included by the top-level module, which checks itself
`ifndef VEC3_LENGTH_AND_NORMALIZE_ASSERT_SVH
`define VEC3_LENGTH_AND_NORMALIZE_ASSERT_SVH

// same-cycle implication, disabled while the active-low rst_n is low
`define V3LN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define V3LN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/v3ln_pkg.sv]
// shared constants for the vec3 length and normalize pipeline
// no dependencies
package v3ln_pkg;
    localparam int COMP_W     = 16;  // Q8.8 component width
    localparam int SUM_W      = 32;  // sum of squares width
    localparam int ROOT_W     = 16;  // length width
    localparam int QUOT_W     = 15;  // unit magnitude width
    localparam int SQRT_PER   = 2;   // root bits per stage
    localparam int SQRT_ST    = 8;   // root stages
    localparam int DIV_STEPS  = 15;  // quotient bits
    localparam int DIV_PER    = 2;   // quotient bits per stage
    localparam int DIV_ST     = 8;   // divide stages
    localparam int LATENCY    = 2 + SQRT_ST + DIV_ST + 1;
    localparam int UNIT_ONE   = 16384;

    typedef logic [COMP_W-1:0] t_mag;
endpackage

[rtl/v3ln_if.sv]
// valid/ready channels for vector words and result words
// depends on v3ln_pkg
interface v3ln_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [v3ln_pkg::COMP_W-1:0] in_x;
    logic signed [v3ln_pkg::COMP_W-1:0] in_y;
    logic signed [v3ln_pkg::COMP_W-1:0] in_z;
    modport source (output valid, in_x, in_y, in_z, input ready);
    modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface v3ln_out_if;
    logic                               valid;
    logic                               ready;
    logic        [v3ln_pkg::ROOT_W-1:0] length;
    logic signed [v3ln_pkg::COMP_W-1:0] unit_x;
    logic signed [v3ln_pkg::COMP_W-1:0] unit_y;
    logic signed [v3ln_pkg::COMP_W-1:0] unit_z;
    logic                               zero_vector;
    modport source (output valid, length, unit_x, unit_y, unit_z, zero_vector, input ready);
    modport sink   (input valid, length, unit_x, unit_y, unit_z, zero_vector, output ready);
endinterface

[rtl/v3ln_sqrt.sv]
// pipelined integer square root, two root bits per stage
// depends on v3ln_pkg
module v3ln_sqrt #(
    parameter int SW = 51
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [v3ln_pkg::SUM_W-1:0]    i_sum,
    input  logic [SW-1:0]                 i_side,
    output logic [v3ln_pkg::ROOT_W-1:0]   o_root,
    output logic [SW-1:0]                 o_side
);
    localparam int NS = v3ln_pkg::SQRT_ST;
    localparam int RW = v3ln_pkg::ROOT_W + 3;

    logic [RW-1:0]                  r_rem  [NS];
    logic [v3ln_pkg::ROOT_W-1:0]    r_q    [NS];
    logic [v3ln_pkg::SUM_W-1:0]     r_n    [NS];
    logic [SW-1:0]                  r_side [NS];

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [RW-1:0]               a_rem, n_rem;
        logic [v3ln_pkg::ROOT_W-1:0] a_q, n_q;
        logic [v3ln_pkg::SUM_W-1:0]  a_n, n_n;
        logic [SW-1:0]               a_side;

        if (s == 0) begin : g_first
            assign a_rem  = '0;
            assign a_q    = '0;
            assign a_n    = i_sum;
            assign a_side = i_side;
        end else begin : g_next
            assign a_rem  = r_rem[s-1];
            assign a_q    = r_q[s-1];
            assign a_n    = r_n[s-1];
            assign a_side = r_side[s-1];
        end

        always_comb begin
            logic [RW-1:0] trial;
            n_rem = a_rem;
            n_q   = a_q;
            n_n   = a_n;
            for (int k = 0; k < v3ln_pkg::SQRT_PER; k++) begin
                // bring down the next two bits, try root*4+1
                n_rem = {n_rem[RW-3:0], n_n[v3ln_pkg::SUM_W-1 -: 2]};
                n_n   = {n_n[v3ln_pkg::SUM_W-3:0], 2'b00};
                trial = {1'b0, n_q, 2'b01};
                if (n_rem >= trial) begin
                    n_rem = n_rem - trial;
                    n_q   = {n_q[v3ln_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    n_q   = {n_q[v3ln_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_q[s]    <= n_q;
                r_n[s]    <= n_n;
                r_side[s] <= a_side;
            end
        end
    end

    assign o_root = r_q[NS-1];
    assign o_side = r_side[NS-1];
endmodule

[rtl/v3ln_div.sv]
// three-lane pipelined restoring divider: (mag << 14) / length
// depends on v3ln_pkg
module v3ln_div #(
    parameter int SW = 20
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [v3ln_pkg::ROOT_W-1:0]   i_den,
    input  v3ln_pkg::t_mag                i_mag [3],
    input  logic [SW-1:0]                 i_side,
    output logic [v3ln_pkg::QUOT_W-1:0]   o_quot [3],
    output logic [SW-1:0]                 o_side
);
    localparam int NS = v3ln_pkg::DIV_ST;
    localparam int DW = v3ln_pkg::ROOT_W;
    localparam int QW = v3ln_pkg::QUOT_W;

    logic [DW-1:0] r_rem  [NS][3];
    logic [QW-1:0] r_q    [NS][3];
    logic [QW-1:0] r_lo   [NS][3];
    logic [DW-1:0] r_den  [NS];
    logic [SW-1:0] r_side [NS];

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [DW-1:0] a_rem [3];
        logic [QW-1:0] a_q   [3];
        logic [QW-1:0] a_lo  [3];
        logic [DW-1:0] a_den;
        logic [SW-1:0] a_side;
        logic [DW-1:0] n_rem [3];
        logic [QW-1:0] n_q   [3];
        logic [QW-1:0] n_lo  [3];

        for (genvar l = 0; l < 3; l++) begin : g_lane
            if (s == 0) begin : g_first
                // quotient fits 15 bits, so the top part of the dividend starts below length
                assign a_rem[l] = {1'b0, i_mag[l][DW-1:1]};
                assign a_q[l]   = '0;
                assign a_lo[l]  = {i_mag[l][0], {(QW-1){1'b0}}};
            end else begin : g_next
                assign a_rem[l] = r_rem[s-1][l];
                assign a_q[l]   = r_q[s-1][l];
                assign a_lo[l]  = r_lo[s-1][l];
            end

            always_comb begin
                logic [DW:0] t;
                n_rem[l] = a_rem[l];
                n_q[l]   = a_q[l];
                n_lo[l]  = a_lo[l];
                for (int k = 0; k < v3ln_pkg::DIV_PER; k++) begin
                    if (s * v3ln_pkg::DIV_PER + k < v3ln_pkg::DIV_STEPS) begin
                        t        = {n_rem[l], n_lo[l][QW-1]};
                        n_lo[l]  = {n_lo[l][QW-2:0], 1'b0};
                        if (t >= {1'b0, a_den}) begin
                            t       = t - {1'b0, a_den};
                            n_q[l]  = {n_q[l][QW-2:0], 1'b1};
                        end else begin
                            n_q[l]  = {n_q[l][QW-2:0], 1'b0};
                        end
                        n_rem[l] = t[DW-1:0];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][l] <= n_rem[l];
                    r_q[s][l]   <= n_q[l];
                    r_lo[s][l]  <= n_lo[l];
                end
            end
        end

        if (s == 0) begin : g_fd
            assign a_den  = i_den;
            assign a_side = i_side;
        end else begin : g_nd
            assign a_den  = r_den[s-1];
            assign a_side = r_side[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s]  <= a_den;
                r_side[s] <= a_side;
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_out
        assign o_quot[l] = r_q[NS-1][l];
    end
    assign o_side = r_side[NS-1];
endmodule

[rtl/vec3_length_and_normalize.sv]
// Vector length and normalization, top level.
// Input channel i_in carries one word per vector: in_x, in_y, in_z, signed Q8.8.
// Output channel o_out carries length (unsigned Q8.8, floor of the root),
// unit_x/y/z (signed Q1.14, truncated toward zero) and zero_vector.
// Every input word gives exactly one output word, in order.
// Stages: squares, sum, 8 root stages of two bits each, 8 divide stages
// of two quotient bits each (the last does one), output register.
// Throughput is one vector per cycle unless o_out stalls; the whole
// pipeline advances on one enable, so occupancy is limited only by
// the output register. When the receiver drops ready with a word waiting,
// the pipeline freezes and i_in.ready falls; nothing is lost or repeated,
// and a bubble in the output register lets the pipeline keep moving.
// A zero vector gives length 0, zero unit components and zero_vector set.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers
// are not reset.
// depends on v3ln_pkg, v3ln_if, v3ln_sqrt, v3ln_div
`include "vec3_length_and_normalize_assert.svh"

module vec3_length_and_normalize (
    input  logic     i_clk,
    input  logic     i_rst_n,
    v3ln_in_if.sink    i_in,
    v3ln_out_if.source o_out
);
    localparam int L   = v3ln_pkg::LATENCY;
    localparam int CW  = v3ln_pkg::COMP_W;
    localparam int SW1 = 3 * CW + 3;
    localparam int SW2 = v3ln_pkg::ROOT_W + 4;
    localparam int QW  = v3ln_pkg::QUOT_W;

    logic [L-1:0] r_v;
    logic         w_en;

    assign w_en       = !r_v[L-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[L-2:0], i_in.valid};
        end
    end

    // stage 1: magnitudes and squares
    logic signed [CW-1:0]    a_c   [3];
    logic [v3ln_pkg::SUM_W-1:0] r_sq [3];
    v3ln_pkg::t_mag          r_mag1 [3];
    logic [2:0]              r_sgn1;

    assign a_c[0] = i_in.in_x;
    assign a_c[1] = i_in.in_y;
    assign a_c[2] = i_in.in_z;

    for (genvar l = 0; l < 3; l++) begin : g_sq
        logic signed [2*CW-1:0] p;
        assign p = a_c[l] * a_c[l];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[l]   <= unsigned'(p);
                r_mag1[l] <= a_c[l][CW-1] ? CW'(-a_c[l]) : unsigned'(a_c[l]);
                r_sgn1[l] <= a_c[l][CW-1];
            end
        end
    end

    // stage 2: sum of squares, below 2^32
    logic [v3ln_pkg::SUM_W-1:0] r_sum;
    logic [SW1-1:0]             r_side2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_side2 <= {r_sgn1, r_mag1[2], r_mag1[1], r_mag1[0]};
        end
    end

    logic [v3ln_pkg::ROOT_W-1:0] w_root;
    logic [SW1-1:0]              w_side3;

    v3ln_sqrt #(.SW(SW1)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sum  (r_sum),
        .i_side (r_side2),
        .o_root (w_root),
        .o_side (w_side3)
    );

    v3ln_pkg::t_mag          w_mag3 [3];
    logic [QW-1:0]           w_quot [3];
    logic [SW2-1:0]          w_side4;

    assign w_mag3[0] = w_side3[CW-1:0];
    assign w_mag3[1] = w_side3[2*CW-1:CW];
    assign w_mag3[2] = w_side3[3*CW-1:2*CW];

    v3ln_div #(.SW(SW2)) u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_den  (w_root),
        .i_mag  (w_mag3),
        .i_side ({w_side3[SW1-1 -: 3], w_root == '0, w_root}),
        .o_quot (w_quot),
        .o_side (w_side4)
    );

    // output register: sign and zero-vector forcing
    logic                          w_zero;
    logic [2:0]                    w_sgn;
    logic signed [CW-1:0]          r_unit [3];
    logic [v3ln_pkg::ROOT_W-1:0]   r_len;
    logic                          r_zero;

    assign w_zero = w_side4[v3ln_pkg::ROOT_W];
    assign w_sgn  = w_side4[SW2-1 -: 3];

    for (genvar l = 0; l < 3; l++) begin : g_unit
        logic [CW-1:0] mag;
        assign mag = {{(CW-QW){1'b0}}, w_quot[l]};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_unit[l] <= w_zero ? '0 : (w_sgn[l] ? signed'(-mag) : signed'(mag));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_len  <= w_side4[v3ln_pkg::ROOT_W-1:0];
            r_zero <= w_zero;
        end
    end

    assign o_out.valid       = r_v[L-1];
    assign o_out.length      = r_len;
    assign o_out.unit_x      = r_unit[0];
    assign o_out.unit_y      = r_unit[1];
    assign o_out.unit_z      = r_unit[2];
    assign o_out.zero_vector = r_zero;

    `V3LN_ASSERT_IMP(a_zero_units, i_clk, i_rst_n,
        o_out.valid && o_out.zero_vector,
        o_out.length == '0 && o_out.unit_x == '0 && o_out.unit_y == '0 && o_out.unit_z == '0,
        "zero vector with nonzero fields")
    `V3LN_ASSERT_IMP(a_len_flag, i_clk, i_rst_n,
        o_out.valid && !o_out.zero_vector, o_out.length != '0,
        "zero length without zero_vector")
    `V3LN_ASSERT_IMP(a_unit_range, i_clk, i_rst_n, o_out.valid,
        r_unit[0] <= v3ln_pkg::UNIT_ONE && r_unit[0] >= -v3ln_pkg::UNIT_ONE &&
        r_unit[1] <= v3ln_pkg::UNIT_ONE && r_unit[1] >= -v3ln_pkg::UNIT_ONE &&
        r_unit[2] <= v3ln_pkg::UNIT_ONE && r_unit[2] >= -v3ln_pkg::UNIT_ONE,
        "unit component out of range")
    `V3LN_ASSERT_NXT(a_stall_freeze, i_clk, i_rst_n, !w_en, $stable(r_v),
        "valid bits moved during stall")
endmodule
